// ===== rtl/qlic_pkg.sv =====
// Package for the quad and line-loop index converter.
// Holds transaction types, primitive codes and converter state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qlic_pkg;

    // Incoming and back-end primitive codes
    localparam logic [3:0] PRIM_LINE_LOOP  = 4'd2;
    localparam logic [3:0] PRIM_LINE_STRIP = 4'd3;
    localparam logic [3:0] PRIM_TRIANGLES  = 4'd4;
    localparam logic [3:0] PRIM_QUADS      = 4'd7;
    localparam logic [3:0] PRIM_QUAD_STRIP = 4'd8;

    // Most results one input transaction can cause
    localparam int unsigned MAX_RESULTS = 6;
    localparam int unsigned CNT_W       = 3;

    typedef struct packed {
        logic [31:0] vertex_index;
        logic        last_in_draw;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_index;
        logic        index_valid;
        logic [3:0]  hw_prim;
        logic        end_of_draw;
        logic        last_of_run;
    } out_item_t;

    // Position in draw is kept as its value mod 4 plus a flag for "four or more";
    // the wrap from the maximum back to four keeps both unchanged.
    typedef struct packed {
        logic [31:0]       first_index;
        logic [2:0][31:0]  held_indices;
        logic [1:0]        pos_lo;
        logic              pos_ge4;
    } conv_state_t;

endpackage

`default_nettype wire

// ===== rtl/qlic_expand.sv =====
// Combinational expansion of one input transaction into its list of results.
// Depends on qlic_pkg for transaction, state and primitive types.
`timescale 1ns / 1ps
`default_nettype none

module qlic_expand
    import qlic_pkg::*;
(
    input  wire logic [3:0]                    prim_type,
    input  wire conv_state_t                   state,
    input  wire in_item_t                      item,
    output      out_item_t [MAX_RESULTS-1:0]   results,
    output      logic [CNT_W-1:0]              result_count,
    output      conv_state_t                   state_next
);

    logic [3:0]  hw_prim;
    logic        pos_zero;
    logic        pos_ge3;
    logic [31:0] first_eff;
    logic [31:0] v;
    logic        last;

    // Map the incoming primitive to what the back end draws
    always_comb
    begin
        case (prim_type)
            PRIM_LINE_LOOP:  hw_prim = PRIM_LINE_STRIP;
            PRIM_QUADS:      hw_prim = PRIM_TRIANGLES;
            PRIM_QUAD_STRIP: hw_prim = PRIM_TRIANGLES;
            default:         hw_prim = prim_type;
        endcase
    end

    assign v         = item.vertex_index;
    assign last      = item.last_in_draw;
    assign pos_zero  = (state.pos_lo == 2'd0) && !state.pos_ge4;
    assign pos_ge3   = (state.pos_lo == 2'd3) || state.pos_ge4;
    assign first_eff = pos_zero ? v : state.first_index;

    // Build the result list and the next state
    always_comb
    begin
        state_next             = state;
        state_next.first_index = first_eff;
        result_count           = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            results[i]             = '0;
            results[i].hw_prim     = hw_prim;
            results[i].index_valid = 1'b1;
        end

        case (prim_type)
            PRIM_QUADS:
            begin
                if (state.pos_lo == 2'd3)
                begin
                    results[0].out_index = state.held_indices[0];
                    results[1].out_index = state.held_indices[1];
                    results[2].out_index = v;
                    results[3].out_index = state.held_indices[1];
                    results[4].out_index = state.held_indices[2];
                    results[5].out_index = v;
                    results[5].end_of_draw = last;
                    result_count = CNT_W'(MAX_RESULTS);
                end
                else
                begin
                    state_next.held_indices[state.pos_lo] = v;
                    if (last)
                    begin
                        results[0].index_valid = 1'b0;
                        results[0].end_of_draw = 1'b1;
                        result_count = CNT_W'(1);
                    end
                end
            end
            PRIM_QUAD_STRIP:
            begin
                if (state.pos_lo[0] && pos_ge3)
                begin
                    results[0].out_index = state.held_indices[0];
                    results[1].out_index = state.held_indices[1];
                    results[2].out_index = v;
                    results[3].out_index = state.held_indices[2];
                    results[4].out_index = state.held_indices[0];
                    results[5].out_index = v;
                    results[5].end_of_draw = last;
                    result_count = CNT_W'(MAX_RESULTS);
                end
                else if (last)
                begin
                    results[0].index_valid = 1'b0;
                    results[0].end_of_draw = 1'b1;
                    result_count = CNT_W'(1);
                end
                state_next.held_indices[0] = state.held_indices[1];
                state_next.held_indices[1] = state.held_indices[2];
                state_next.held_indices[2] = v;
            end
            PRIM_LINE_LOOP:
            begin
                results[0].out_index   = v;
                results[0].end_of_draw = last;
                result_count = CNT_W'(1);
                // Close the loop with a second draw from last back to first
                if (last)
                begin
                    results[1].out_index   = v;
                    results[2].out_index   = first_eff;
                    results[2].end_of_draw = 1'b1;
                    result_count = CNT_W'(3);
                end
            end
            default:
            begin
                results[0].out_index   = v;
                results[0].end_of_draw = last;
                result_count = CNT_W'(1);
            end
        endcase

        // Flag the final result of this transaction
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            results[i].last_of_run = (CNT_W'(i + 1) == result_count);
        end

        // Advance the position; restart on the last index
        if (last)
        begin
            state_next.pos_lo  = 2'd0;
            state_next.pos_ge4 = 1'b0;
        end
        else
        begin
            state_next.pos_lo  = state.pos_lo + 2'd1;
            state_next.pos_ge4 = state.pos_ge4 || (state.pos_lo == 2'd3);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/quad_and_loop_index_converter_core.sv =====
// Top level of the quad and line-loop index converter: expansion logic, result shift line.
// Depends on qlic_pkg and qlic_expand.
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   src     | src_valid, src_ready, src_data   | one vertex index per transaction
//   dst     | dst_valid, dst_ready, dst_data   | one emitted result per transaction
//   cfg     | cfg_we, cfg_data                 | prim_type write, no wait
//
// An input transaction is expanded combinationally into a shift line of up to six results,
// which drains one result per cycle on dst while dst_ready is high. A transaction has as
// many results as it causes (1 for pass-through, 3 for a line loop end, 6 per completed
// quad) or none. src_ready is high while the line holds at most the result being taken.
// Reset clears the state and primitive type at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module quad_and_loop_index_converter_core
    import qlic_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    output      logic        src_ready,
    input  wire in_item_t    src_data,
    output      logic        dst_valid,
    input  wire logic        dst_ready,
    output      out_item_t   dst_data,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_data
);

    logic [3:0]                   prim_reg;
    conv_state_t                  state_reg;
    conv_state_t                  state_next;
    out_item_t [MAX_RESULTS-1:0]  slots_reg;
    out_item_t [MAX_RESULTS-1:0]  slots_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    out_item_t [MAX_RESULTS-1:0]  exp_results;
    logic [CNT_W-1:0]             exp_count;
    conv_state_t                  exp_state;
    logic                         src_fire;
    logic                         dst_fire;

    qlic_expand u_expand (
        .prim_type    (prim_reg),
        .state        (state_reg),
        .item         (src_data),
        .results      (exp_results),
        .result_count (exp_count),
        .state_next   (exp_state)
    );

    assign dst_valid = (count_reg != '0);
    assign dst_data  = slots_reg[0];
    assign dst_fire  = dst_valid && dst_ready;
    assign src_ready = (count_reg == '0) || ((count_reg == CNT_W'(1)) && dst_ready);
    assign src_fire  = src_valid && src_ready;

    // Load a new result list, or shift the line on each taken result
    always_comb
    begin
        slots_next = slots_reg;
        count_next = count_reg;
        state_next = state_reg;
        if (src_fire)
        begin
            slots_next = exp_results;
            count_next = exp_count;
            state_next = exp_state;
        end
        else if (dst_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slots_next[i] = slots_reg[i + 1];
            end
            count_next = count_reg - CNT_W'(1);
        end
        // A primitive write starts a fresh draw
        if (cfg_we)
        begin
            state_next.pos_lo  = 2'd0;
            state_next.pos_ge4 = 1'b0;
        end
    end

    // Hold control and converter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_reg  <= '0;
            state_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                prim_reg <= cfg_data;
            end
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

    // The line never holds more than one transaction's results
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count exceeds line depth");

    // The result marked last of run is the only one left in the line
    a_last_of_run: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.last_of_run |-> count_reg == CNT_W'(1))
        else $error("last_of_run not on final queued result");

    // A marker-only result always ends the draw and the run
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_data.index_valid |->
            dst_data.end_of_draw && dst_data.last_of_run && dst_data.out_index == '0)
        else $error("malformed marker-only result");

    // A taken result that is not last of run is followed by another result
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        dst_fire && !dst_data.last_of_run |=> dst_valid)
        else $error("run ended early");

endmodule

`default_nettype wire

// ===== sim/qlic_checker.sv =====
// Checker for the quad and line-loop index converter: watches the src, dst and cfg ports,
// predicts the emitted index stream and compares each dst transaction against it.
// Depends on qlic_pkg.
`timescale 1ns / 1ps

module qlic_checker
    import qlic_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        src_valid,
    input  wire logic        src_ready,
    input  wire in_item_t    src_data,
    input  wire logic        dst_valid,
    input  wire logic        dst_ready,
    input  wire out_item_t   dst_data,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_data,
    output int unsigned      fail_count,
    output int unsigned      outstanding
);

    // Shadow of the converter state
    logic [3:0]  prim_type;
    logic [31:0] first_index;
    logic [31:0] held [3];
    logic [31:0] position;

    // Results of the transaction being expanded, and the stream still owed on dst
    out_item_t   burst [MAX_RESULTS];
    int unsigned burst_n;
    out_item_t   emitted_q [$];
    out_item_t   taken;

    function automatic logic [3:0] back_end_code(input logic [3:0] p);
        case (p)
            PRIM_LINE_LOOP:              return PRIM_LINE_STRIP;
            PRIM_QUADS, PRIM_QUAD_STRIP: return PRIM_TRIANGLES;
            default:                     return p;
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic stage(input logic [31:0] idx, input logic carries, input logic closes);
        out_item_t r;
        r.out_index   = idx;
        r.index_valid = carries;
        r.hw_prim     = back_end_code(prim_type);
        r.end_of_draw = closes;
        r.last_of_run = 1'b0;
        burst[burst_n] = r;
        burst_n++;
    endtask

    // Stage two triangles; the draw closes on the sixth index if the input was the last one
    task automatic stage_pair(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                              input logic [31:0] d, input logic [31:0] e, input logic [31:0] f,
                              input logic closes);
        stage(a, 1'b1, 1'b0);
        stage(b, 1'b1, 1'b0);
        stage(c, 1'b1, 1'b0);
        stage(d, 1'b1, 1'b0);
        stage(e, 1'b1, 1'b0);
        stage(f, 1'b1, closes);
    endtask

    // Expand one accepted index into the results it causes and advance the draw state
    task automatic expand_index(input in_item_t t);
        logic [31:0] v;
        logic        last;
        logic [31:0] pos;
        out_item_t   r;
        v = t.vertex_index;
        last = t.last_in_draw;
        pos = position;
        burst_n = 0;
        if (pos == '0)
            first_index = v;

        if (prim_type == PRIM_QUADS) begin
            if (pos[1:0] == 2'd3) begin
                stage_pair(held[0], held[1], v, held[1], held[2], v, last);
            end
            else begin
                held[pos[1:0]] = v;
                if (last)
                    stage('0, 1'b0, 1'b1);
            end
        end
        else if (prim_type == PRIM_QUAD_STRIP) begin
            if (pos[0] && pos >= 32'd3)
                stage_pair(held[0], held[1], v, held[2], held[0], v, last);
            else if (last)
                stage('0, 1'b0, 1'b1);
            held[0] = held[1];
            held[1] = held[2];
            held[2] = v;
        end
        else if (prim_type == PRIM_LINE_LOOP) begin
            stage(v, 1'b1, last);
            // close the loop with a second draw: last, first
            if (last) begin
                stage(v, 1'b1, 1'b0);
                stage(first_index, 1'b1, 1'b1);
            end
        end
        else begin
            stage(v, 1'b1, last);
        end

        if (last)
            position = '0;
        else if (pos == '1)
            position = 32'd4;
        else
            position = pos + 32'd1;

        for (int k = 0; k < burst_n; k++) begin
            r = burst[k];
            r.last_of_run = (k == burst_n - 1);
            emitted_q.push_back(r);
        end
    endtask

    // Compare dst, apply register writes, then predict from src
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prim_type   = '0;
            first_index = '0;
            held[0]     = '0;
            held[1]     = '0;
            held[2]     = '0;
            position    = '0;
            emitted_q.delete();
            fail_count  = 0;
            outstanding <= 0;
        end
        else begin
            if (dst_valid && dst_ready) begin
                if (emitted_q.size() == 0) begin
                    report("unexpected result, out_index", dst_data.out_index, '0);
                end
                else begin
                    taken = emitted_q.pop_front();
                    if (dst_data.out_index !== taken.out_index)
                        report("out_index", dst_data.out_index, taken.out_index);
                    if (dst_data.index_valid !== taken.index_valid)
                        report("index_valid", 32'(dst_data.index_valid),
                               32'(taken.index_valid));
                    if (dst_data.hw_prim !== taken.hw_prim)
                        report("hw_prim", 32'(dst_data.hw_prim), 32'(taken.hw_prim));
                    if (dst_data.end_of_draw !== taken.end_of_draw)
                        report("end_of_draw", 32'(dst_data.end_of_draw),
                               32'(taken.end_of_draw));
                    if (dst_data.last_of_run !== taken.last_of_run)
                        report("last_of_run", 32'(dst_data.last_of_run),
                               32'(taken.last_of_run));
                end
            end
            // a register write also starts a fresh draw
            if (cfg_we) begin
                prim_type = cfg_data;
                position  = '0;
            end
            if (src_valid && src_ready)
                expand_index(src_data);
            outstanding <= emitted_q.size();
        end
    end

endmodule

// ===== sim/tb_quad_and_loop_index_converter_core.sv =====
// Testbench top for the quad and line-loop index converter: clock, reset, draw stimulus,
// random stalls on both channels and the final verdict.
// Depends on qlic_pkg, quad_and_loop_index_converter_core and qlic_checker.
`timescale 1ns / 1ps

module tb_quad_and_loop_index_converter_core;
    import qlic_pkg::*;

    // Primitive codes the package does not name
    localparam logic [3:0] PRIM_POINTS       = 4'd0;
    localparam logic [3:0] PRIM_UNLISTED_MAX = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_ready;
    in_item_t    src_data;
    logic        dst_valid;
    logic        dst_ready;
    out_item_t   dst_data;
    logic        cfg_we;
    logic [3:0]  cfg_data;
    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned random_sent;
    bit          steady;

    quad_and_loop_index_converter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    qlic_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_data    (src_data),
        .dst_valid   (dst_valid),
        .dst_ready   (dst_ready),
        .dst_data    (dst_data),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one; none while running steady
    function automatic int unsigned gap_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [31:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic logic [3:0] pick_prim();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return PRIM_QUADS;
        if (r < 13)
            return PRIM_QUAD_STRIP;
        if (r < 16)
            return PRIM_LINE_LOOP;
        return 4'($urandom_range(PRIM_POINTS, PRIM_UNLISTED_MAX));
    endfunction

    // Draw lengths: mostly whole groups for quads and quad strips, broken ones now and then
    function automatic int unsigned draw_len(input logic [3:0] p);
        int unsigned r;
        r = $urandom_range(0, 3);
        if (p == PRIM_QUADS)
            return (r < 3) ? 4 * $urandom_range(1, 2) : $urandom_range(1, 7);
        if (p == PRIM_QUAD_STRIP)
            return (r < 3) ? 2 * $urandom_range(2, 4) : $urandom_range(1, 5);
        return $urandom_range(1, 6);
    endfunction

    // Offer one index transaction after a random gap and hold it until accepted
    task automatic push_index(input logic [31:0] v, input logic closes);
        int unsigned gap;
        in_item_t    t;
        gap = gap_len();
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.vertex_index = v;
        t.last_in_draw = closes;
        src_valid <= 1'b1;
        src_data  <= t;
        do @(posedge clk); while (!src_ready);
    endtask

    // Drop valid and hold until every owed result has left dst
    task automatic await_quiet();
        src_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Write the primitive type once the converter is idle
    task automatic load_prim_type(input logic [3:0] p);
        await_quiet();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= p;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Stall the result channel at random
    initial
    begin
        int unsigned hold;
        hold = 0;
        dst_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                dst_ready <= 1'b0;
                hold--;
            end
            else begin
                dst_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    hold = gap_len();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int unsigned draws;
        int unsigned len;
        logic [3:0]  p;
        bit          abandon;
        steady = 1'b0;
        random_sent = 0;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_data  <= '0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Quads: one full group, a trailing partial group, then an abandoned draw restarted
        load_prim_type(PRIM_QUADS);
        push_index(32'h0000_0000, 1'b0);
        push_index(32'hFFFF_FFFF, 1'b0);
        push_index(32'h1234_5678, 1'b0);
        push_index(32'h8000_0001, 1'b1);
        push_index(32'h0000_0011, 1'b0);
        push_index(32'h0000_0022, 1'b0);
        push_index(32'h0000_0033, 1'b1);
        push_index(32'hDEAD_BEEF, 1'b0);
        push_index(32'h7FFF_FFFF, 1'b0);
        load_prim_type(PRIM_QUADS);
        push_index(32'h0000_0100, 1'b0);
        push_index(32'h0000_0101, 1'b0);
        push_index(32'h0000_0102, 1'b0);
        push_index(32'h0000_0103, 1'b1);

        // Quad strip: one pair after the first, then a lone last index
        load_prim_type(PRIM_QUAD_STRIP);
        push_index(32'hFFFF_FFFF, 1'b0);
        push_index(32'h0000_0000, 1'b0);
        push_index(32'hAAAA_5555, 1'b0);
        push_index(32'h5555_AAAA, 1'b1);
        await_quiet();
        push_index(32'h0000_0042, 1'b1);

        // Line loop: a three-index loop and a loop of one index
        load_prim_type(PRIM_LINE_LOOP);
        push_index(32'h0000_0007, 1'b0);
        push_index(32'hFFFF_FFFE, 1'b0);
        push_index(32'h0000_0001, 1'b1);
        push_index(32'h0BAD_F00D, 1'b1);

        // Pass-through at both ends of the code range
        load_prim_type(PRIM_UNLISTED_MAX);
        push_index(32'hFFFF_FFFF, 1'b1);
        load_prim_type(PRIM_POINTS);
        push_index(32'h0000_0000, 1'b1);

        // Random phases of well-formed draws with broken and abandoned ones mixed in
        while (random_sent < 90) begin
            p = pick_prim();
            steady = ($urandom_range(0, 3) == 0);
            load_prim_type(p);
            draws = $urandom_range(1, 4);
            for (int d = 0; d < draws; d++) begin
                len = draw_len(p);
                abandon = (d == draws - 1) && ($urandom_range(0, 7) == 0);
                for (int k = 0; k < len; k++) begin
                    push_index(pick_index(), (k == len - 1) && !abandon);
                    random_sent++;
                end
                if ($urandom_range(0, 9) == 0)
                    await_quiet();
            end
        end

        // Drain and let the converter settle
        src_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
